// ===== rtl/lsd_pkg.sv =====
package lsd_pkg;

  // Fixed point: speed difference and gains carry FracBits fraction bits
  localparam int FracBits = 8;

  // 100 percent torque in Q7.8
  localparam logic [14:0] TorqueFull = 15'd25600;

  // Unity of the faster-wheel factor once the common FracBits scale is dropped
  localparam int          FastW   = 2 * FracBits + 1;
  localparam logic [FastW-1:0] FastOne = FastW'(1) << (2 * FracBits);

  // Slower-wheel extra term X is split at 3*FracBits into whole and fraction
  localparam int SplitBit = 3 * FracBits;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgEnable    = 3'd0,
    CfgThreshold = 3'd1,
    CfgLimit     = 3'd2,
    CfgKGain     = 3'd3,
    CfgMGain     = 3'd4,
    CfgLGain     = 3'd5
  } cfg_idx_e;

  // faster_side codes
  localparam logic [1:0] SideNone  = 2'd0;
  localparam logic [1:0] SideLeft  = 2'd1;
  localparam logic [1:0] SideRight = 2'd2;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold;
    logic [14:0] limit;
    logic [15:0] k_gain;
    logic [15:0] m_gain;
    logic [15:0] l_gain;
  } cfg_t;

  // Beat handed from the factor stages to the scaling stages
  typedef struct packed {
    logic [14:0]      torque;
    logic             neg;        // right wheel faster
    logic             pass;       // pass command through
    logic [46:0]      p_slow;     // min(a,L)*k*m
    logic [31:0]      p_ext;      // l*(a-L) beyond the knee
    logic             fast_zero;  // faster factor not positive
    logic [FastW-1:0] fast_fac;   // faster factor, 2*FracBits fraction bits
  } fac_t;

endpackage

// ===== rtl/lsd_cfg.sv =====
module lsd_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_wdata_i,
  output lsd_pkg::cfg_t        cfg_o
);
  import lsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEnable:    cfg_d.enable    = cfg_wdata_i[0];
        CfgThreshold: cfg_d.threshold = cfg_wdata_i;
        CfgLimit:     cfg_d.limit     = cfg_wdata_i[14:0];
        CfgKGain:     cfg_d.k_gain    = cfg_wdata_i;
        CfgMGain:     cfg_d.m_gain    = cfg_wdata_i;
        CfgLGain:     cfg_d.l_gain    = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b1;
      cfg_q.threshold <= 16'd0;
      cfg_q.limit     <= 15'd0;
      cfg_q.k_gain    <= 16'd0;
      cfg_q.m_gain    <= 16'd256;
      cfg_q.l_gain    <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lsd_factor.sv =====
module lsd_factor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  input  logic [14:0]          torque_command_i,
  input  logic signed [15:0]   rear_difference_i,
  input  logic [15:0]          chassis_speed_i,
  input  logic                 diff_error_i,
  input  lsd_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output lsd_pkg::fac_t        fac_o
);
  import lsd_pkg::*;

  logic [15:0] diff_u;
  logic        neg;
  logic [15:0] abs_d;
  logic        over;
  logic [14:0] base;
  logic [15:0] excess;
  logic        pass_d;
  logic [30:0] p_lin_d;
  logic [31:0] p_ext_d;

  logic        v1_q;
  logic [14:0] t1_q;
  logic        neg1_q;
  logic        pass1_q;
  logic [30:0] p_lin1_q;
  logic [31:0] p_ext1_q;

  logic [32:0] s_sum;
  fac_t        fac_d;
  logic        v2_q;
  fac_t        fac_q;

  // Stage 1: magnitude, knee split, first products
  assign diff_u  = rear_difference_i;
  assign neg     = diff_u[15];
  assign abs_d   = neg ? (16'd0 - diff_u) : diff_u;
  assign over    = abs_d > {1'b0, cfg_i.limit};
  assign base    = over ? cfg_i.limit : abs_d[14:0];
  assign excess  = over ? (abs_d - {1'b0, cfg_i.limit}) : 16'd0;
  assign pass_d  = !cfg_i.enable || diff_error_i ||
                   (chassis_speed_i <= cfg_i.threshold) || (diff_u == 16'd0);
  assign p_lin_d = 31'(base) * 31'(cfg_i.k_gain);
  assign p_ext_d = 32'(cfg_i.l_gain) * 32'(excess);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t1_q     <= torque_command_i;
      neg1_q   <= neg;
      pass1_q  <= pass_d;
      p_lin1_q <= p_lin_d;
      p_ext1_q <= p_ext_d;
    end
  end

  // Stage 2: slower-wheel gain product, faster-wheel factor
  assign s_sum = 33'(p_lin1_q) + 33'(p_ext1_q);

  always_comb begin
    fac_d.torque    = t1_q;
    fac_d.neg       = neg1_q;
    fac_d.pass      = pass1_q;
    fac_d.p_slow    = 47'(p_lin1_q) * 47'(cfg_i.m_gain);
    fac_d.p_ext     = p_ext1_q;
    fac_d.fast_zero = |s_sum[32:2*FracBits];
    fac_d.fast_fac  = FastOne - FastW'(s_sum[2*FracBits-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fac_q <= fac_d;
    end
  end

  assign valid_o = v2_q;
  assign fac_o   = fac_q;

endmodule

// ===== rtl/lsd_scale.sv =====
module lsd_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  lsd_pkg::fac_t        fac_i,
  output logic                 out_valid_o,
  output logic [14:0]          torque_left_o,
  output logic [14:0]          torque_right_o,
  output logic [1:0]           faster_side_o
);
  import lsd_pkg::*;

  logic [47:0] x_sum;
  logic [30:0] f_prod;

  logic        v3_q;
  logic [14:0] t3_q;
  logic        neg3_q;
  logic        pass3_q;
  logic        sat3_q;
  logic [15:0] xh3_q;
  logic [23:0] xl3_q;
  logic [14:0] fast3_q;

  logic [30:0] ph_d;
  logic [38:0] pl_d;

  logic        v4_q;
  logic [14:0] t4_q;
  logic        neg4_q;
  logic        pass4_q;
  logic        sat4_q;
  logic [14:0] fast4_q;
  logic [30:0] ph4_q;
  logic [14:0] plh4_q;

  logic [31:0] slow_sum;
  logic [14:0] slow_t;
  logic        v5_q;
  logic [14:0] left_q, left_d;
  logic [14:0] right_q, right_d;
  logic [1:0]  side_q, side_d;

  // Stage 3: slower extra term X, faster-wheel product
  assign x_sum  = 48'(fac_i.p_slow) + (48'(fac_i.p_ext) << FracBits);
  assign f_prod = 31'(fac_i.torque) * 31'(fac_i.fast_fac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t3_q    <= fac_i.torque;
      neg3_q  <= fac_i.neg;
      pass3_q <= fac_i.pass;
      sat3_q  <= |x_sum[47:SplitBit+16];
      xh3_q   <= x_sum[SplitBit+15:SplitBit];
      xl3_q   <= x_sum[SplitBit-1:0];
      fast3_q <= fac_i.fast_zero ? 15'd0 : f_prod[2*FracBits+14:2*FracBits];
    end
  end

  // Stage 4: T times whole and fraction parts of X
  assign ph_d = 31'(t3_q) * 31'(xh3_q);
  assign pl_d = 39'(t3_q) * 39'(xl3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t4_q    <= t3_q;
      neg4_q  <= neg3_q;
      pass4_q <= pass3_q;
      sat4_q  <= sat3_q;
      fast4_q <= fast3_q;
      ph4_q   <= ph_d;
      plh4_q  <= pl_d[SplitBit+14:SplitBit];
    end
  end

  // Stage 5: slower torque with saturation, wheel assignment
  assign slow_sum = 32'(t4_q) + 32'(ph4_q) + 32'(plh4_q);

  always_comb begin
    if ((sat4_q && (t4_q != 15'd0)) || (slow_sum > 32'(TorqueFull))) begin
      slow_t = TorqueFull;
    end else begin
      slow_t = slow_sum[14:0];
    end
    if (pass4_q) begin
      left_d  = t4_q;
      right_d = t4_q;
      side_d  = SideNone;
    end else if (!neg4_q) begin
      left_d  = fast4_q;
      right_d = slow_t;
      side_d  = SideLeft;
    end else begin
      left_d  = slow_t;
      right_d = fast4_q;
      side_d  = SideRight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      side_q  <= side_d;
    end
  end

  assign out_valid_o    = v5_q;
  assign torque_left_o  = left_q;
  assign torque_right_o = right_q;
  assign faster_side_o  = side_q;

endmodule

// ===== rtl/lsd_torque_split.sv =====
// Throughput: one beat per cycle while no valid output beat is stalled;
// the 5-stage multiplier pipeline sets it. Such a stall freezes all stages
// and raises in_stall_o in the same cycle.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// register defaults: enable 1, m_gain 256, all other registers 0.
module lsd_torque_split (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [14:0]          torque_command_i,
  input  logic signed [15:0]   rear_difference_i,
  input  logic [15:0]          chassis_speed_i,
  input  logic                 diff_error_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [14:0]          torque_left_o,
  output logic [14:0]          torque_right_o,
  output logic [1:0]           faster_side_o
);
  import lsd_pkg::*;

  cfg_t cfg;
  fac_t fac;
  logic fac_valid;
  logic adv;

  // Whole pipe moves unless the output beat is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  lsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lsd_factor u_factor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .in_valid_i        (in_valid_i),
    .torque_command_i  (torque_command_i),
    .rear_difference_i (rear_difference_i),
    .chassis_speed_i   (chassis_speed_i),
    .diff_error_i      (diff_error_i),
    .cfg_i             (cfg),
    .valid_o           (fac_valid),
    .fac_o             (fac)
  );

  lsd_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (fac_valid),
    .fac_i          (fac),
    .out_valid_o    (out_valid_o),
    .torque_left_o  (torque_left_o),
    .torque_right_o (torque_right_o),
    .faster_side_o  (faster_side_o)
  );

endmodule

// ===== rtl/lsd_checker.sv =====
module lsd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [14:0]          torque_left_o,
  input logic [14:0]          torque_right_o,
  input logic [1:0]           faster_side_o
);
  import lsd_pkg::*;

  // Held output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  // Held output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(torque_left_o) &&
      $stable(torque_right_o) && $stable(faster_side_o))
    else $error("output payload changed under stall");

  // Input is only held back by a held output beat
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Side code is one of the three defined values
  a_side_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (faster_side_o == SideNone) || (faster_side_o == SideLeft) ||
      (faster_side_o == SideRight))
    else $error("undefined faster_side code");

  // Slower wheel never exceeds full torque
  a_slow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((faster_side_o != SideLeft) || (torque_right_o <= TorqueFull)) &&
      ((faster_side_o != SideRight) || (torque_left_o <= TorqueFull)))
    else $error("slower wheel torque above saturation");

endmodule

bind lsd_torque_split lsd_checker u_lsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .torque_left_o  (torque_left_o),
  .torque_right_o (torque_right_o),
  .faster_side_o  (faster_side_o)
);
